### src/bhcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhcv_pkg;

    // header layout
    localparam int CRC_SPAN     = 252;
    localparam int HEADER_BYTES = 256;
    localparam int CNT_W        = $clog2(HEADER_BYTES + 1);

    // field widths
    localparam int SIZE_W = 25;
    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // crc-32/mpeg-2 constants
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // register reset values
    localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = SIZE_W'(100 * 1024);
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = SIZE_W'(1024 * 1024);

    // register indexes (byte address is 4 * index)
    localparam logic REG_MIN_SIZE = 1'b0;
    localparam logic REG_MAX_SIZE = 1'b1;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_PASS       = 3'd0,
        VERDICT_NOT_STAGED = 3'd1,
        VERDICT_TOO_SMALL  = 3'd2,
        VERDICT_TOO_LARGE  = 3'd3,
        VERDICT_CRC_BAD    = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [SIZE_W-1:0] min_size;
        logic [SIZE_W-1:0] max_size;
    } cfg_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [CRC_W-1:0] computed_crc;
        logic [CRC_W-1:0] stored_crc;
    } result_t;

endpackage

`default_nettype wire

### src/bhcv_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bhcv_cfg_regs
    import bhcv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [SIZE_W-1:0] min_size_reg, min_size_next;
    logic [SIZE_W-1:0] max_size_reg, max_size_next;
    logic              wr_en;
    logic              reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    // register write decode
    always_comb begin
        min_size_next = min_size_reg;
        max_size_next = max_size_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_MIN_SIZE: min_size_next = pwdata[SIZE_W-1:0];
                REG_MAX_SIZE: max_size_next = pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_size_reg <= MIN_SIZE_RESET;
            max_size_reg <= MAX_SIZE_RESET;
        end else begin
            min_size_reg <= min_size_next;
            max_size_reg <= max_size_next;
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_MIN_SIZE: prdata = DATA_W'(min_size_reg);
            REG_MAX_SIZE: prdata = DATA_W'(max_size_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.min_size = min_size_reg;
    assign cfg.max_size = max_size_reg;

endmodule

`default_nettype wire

### src/bhcv_crc8.sv
`timescale 1ns / 1ps
`default_nettype none

module bhcv_crc8
    import bhcv_pkg::*;
(
    input  wire logic [CRC_W-1:0]  crc_in,
    input  wire logic [BYTE_W-1:0] data_in,
    output logic      [CRC_W-1:0]  crc_out
);

    // msb-first crc update, one byte unrolled over eight bit steps
    always_comb begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data_in, {(CRC_W - BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

### src/bhcv_session.sv
`timescale 1ns / 1ps
`default_nettype none

module bhcv_session
    import bhcv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic              command,
    input  wire logic [SIZE_W-1:0] image_size,
    input  wire logic              staged,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire cfg_t              cfg,
    output logic                   res_valid,
    output result_t                res
);

    logic [CRC_W-1:0] crc_acc_reg, crc_acc_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [CRC_W-1:0] stored_word_reg, stored_word_next;
    logic             active_reg, active_next;
    logic [CRC_W-1:0] crc_upd;
    logic [1:0]       lane;

    bhcv_crc8 u_crc8 (
        .crc_in  (crc_acc_reg),
        .data_in (data_byte),
        .crc_out (crc_upd)
    );

    assign lane = 2'(byte_count_reg - CNT_W'(CRC_SPAN));

    // session update and verdict
    always_comb begin
        crc_acc_next     = crc_acc_reg;
        byte_count_next  = byte_count_reg;
        stored_word_next = stored_word_reg;
        active_next      = active_reg;
        res_valid        = 1'b0;
        res.verdict      = VERDICT_PASS;
        res.computed_crc = '0;
        res.stored_crc   = '0;
        if (step_en) begin
            if (command == CMD_START) begin
                crc_acc_next     = CRC_INIT;
                byte_count_next  = '0;
                stored_word_next = '0;
                active_next      = 1'b0;
                if (!staged) begin
                    res_valid   = 1'b1;
                    res.verdict = VERDICT_NOT_STAGED;
                end else if (image_size < cfg.min_size) begin
                    res_valid   = 1'b1;
                    res.verdict = VERDICT_TOO_SMALL;
                end else if (image_size > cfg.max_size) begin
                    res_valid   = 1'b1;
                    res.verdict = VERDICT_TOO_LARGE;
                end else begin
                    active_next = 1'b1;
                end
            end else if (active_reg) begin
                if (byte_count_reg < CNT_W'(CRC_SPAN)) begin
                    crc_acc_next = crc_upd;
                end else if (byte_count_reg < CNT_W'(CRC_SPAN + 4)) begin
                    stored_word_next = stored_word_reg
                                     | (CRC_W'(data_byte) << {lane, 3'b000});
                end
                byte_count_next = byte_count_reg + CNT_W'(1);
                if (byte_count_next >= CNT_W'(HEADER_BYTES)) begin
                    res_valid        = 1'b1;
                    res.verdict      = (crc_acc_next == stored_word_next) ?
                                       VERDICT_PASS : VERDICT_CRC_BAD;
                    res.computed_crc = crc_acc_next;
                    res.stored_crc   = stored_word_next;
                    active_next      = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_acc_reg     <= CRC_INIT;
            byte_count_reg  <= '0;
            stored_word_reg <= '0;
            active_reg      <= 1'b0;
        end else begin
            crc_acc_reg     <= crc_acc_next;
            byte_count_reg  <= byte_count_next;
            stored_word_reg <= stored_word_next;
            active_reg      <= active_next;
        end
    end

endmodule

`default_nettype wire

### src/boot_header_crc_validator.sv
`timescale 1ns / 1ps
`default_nettype none

// Boot-header validator for a staged firmware image.
// Input channel (s_*): one beat per item. A start beat (s_command = 0) carries
// s_image_size and s_staged; a bad flag or an out-of-range size yields a
// failure result at once. Otherwise the next 256 byte beats (s_command = 1)
// are the image header: crc-32/mpeg-2 over bytes 0..251, bytes 252..255 are
// the little-endian stored crc. The 256th byte yields pass or crc-bad.
// Byte beats outside a session are dropped; a start restarts the session.
// Result channel (m_*): at most one beat per input beat, m_verdict plus the
// computed and stored crc (zero for failures at start).
// Path: an accepted beat is loaded into the input register, and the session logic
// loads its result into the result register when the result side can advance.
// Throughput: one beat per cycle while the result side is not stalled, bounded
// by the combinational unrolled byte crc update.
// Stall: while a result waits on m_ready, one more beat is held in the input
// register; s_ready drops only when both are full.
// Reset (aresetn, synchronous): session idle, size limits back to
// 102400 / 1048576 bytes. Limits are written over the apb port at 0x0 / 0x4.
module boot_header_crc_validator
    import bhcv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [SIZE_W-1:0] s_image_size,
    input  wire logic              s_staged,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [2:0]        m_verdict,
    output logic      [CRC_W-1:0]  m_computed_crc,
    output logic      [CRC_W-1:0]  m_stored_crc,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic              in_command_reg;
    logic [SIZE_W-1:0] in_image_size_reg;
    logic              in_staged_reg;
    logic [BYTE_W-1:0] in_data_byte_reg;
    logic              m_valid_reg;
    result_t           m_result_reg;
    logic              advance;
    logic              step_en;
    logic              res_valid;
    result_t           res;

    bhcv_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline flow control
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step_en = in_valid_reg && advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg    <= s_command;
            in_image_size_reg <= s_image_size;
            in_staged_reg     <= s_staged;
            in_data_byte_reg  <= s_data_byte;
        end
    end

    bhcv_session u_session (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .command    (in_command_reg),
        .image_size (in_image_size_reg),
        .staged     (in_staged_reg),
        .data_byte  (in_data_byte_reg),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= step_en && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            m_result_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict      = m_result_reg.verdict;
    assign m_computed_crc = m_result_reg.computed_crc;
    assign m_stored_crc   = m_result_reg.stored_crc;

    // checks
    a_pass_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_PASS) |-> (m_computed_crc == m_stored_crc))
        else $error("pass reported with differing crc values");

    a_bad_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_CRC_BAD) |-> (m_computed_crc != m_stored_crc))
        else $error("crc failure reported with equal crc values");

    a_start_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_NOT_STAGED || m_verdict == VERDICT_TOO_SMALL
                    || m_verdict == VERDICT_TOO_LARGE)
        |-> (m_computed_crc == '0) && (m_stored_crc == '0))
        else $error("start failure carries nonzero crc fields");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && in_valid_reg)
        else $error("input stalled without a held result");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import bhcv_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int SIZE_TOP        = 1 << 24;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int STORED_BYTES    = 4;

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic              s_command      = CMD_START;
    logic [SIZE_W-1:0] s_image_size   = '0;
    logic              s_staged       = 1'b0;
    logic [BYTE_W-1:0] s_data_byte    = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [2:0]        m_verdict;
    logic [CRC_W-1:0]  m_computed_crc;
    logic [CRC_W-1:0]  m_stored_crc;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [DATA_W-1:0] pwdata         = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    boot_header_crc_validator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_image_size   (s_image_size),
        .s_staged       (s_staged),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_computed_crc (m_computed_crc),
        .m_stored_crc   (m_stored_crc),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // shadow of the size limits and the running header session
    logic [SIZE_W-1:0] lim_min    = MIN_SIZE_RESET;
    logic [SIZE_W-1:0] lim_max    = MAX_SIZE_RESET;
    logic [CRC_W-1:0]  crc_run    = CRC_INIT;
    logic [CNT_W-1:0]  hdr_count  = '0;
    logic [CRC_W-1:0]  stored_acc = '0;
    bit                in_session = 1'b0;

    result_t awaited_verdicts[$];
    int      items_sent   = 0;
    int      verdicts_due = 0;
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    bit      gaps_on      = 1'b1;
    bit      stall_on     = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // one byte of crc-32/mpeg-2, msb first
    function automatic logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
        c ^= CRC_W'(b) << (CRC_W - BYTE_W);
        for (int k = 0; k < BYTE_W; k++)
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void queue_verdict(verdict_t v, logic [CRC_W-1:0] comp,
                                          logic [CRC_W-1:0] stor);
        result_t r;
        r.verdict      = v;
        r.computed_crc = comp;
        r.stored_crc   = stor;
        awaited_verdicts.push_back(r);
        verdicts_due++;
    endfunction

    // advance the shadow session by one accepted beat; 0 if the beat is dropped
    function automatic bit predict_verdict(logic cmd, logic [SIZE_W-1:0] size, logic st,
                                           logic [BYTE_W-1:0] b);
        if (cmd == CMD_START) begin
            crc_run    = CRC_INIT;
            hdr_count  = '0;
            stored_acc = '0;
            in_session = 1'b0;
            if (!st)
                queue_verdict(VERDICT_NOT_STAGED, '0, '0);
            else if (size < lim_min)
                queue_verdict(VERDICT_TOO_SMALL, '0, '0);
            else if (size > lim_max)
                queue_verdict(VERDICT_TOO_LARGE, '0, '0);
            else
                in_session = 1'b1;
            return 1'b1;
        end
        if (!in_session)
            return 1'b0;
        if (hdr_count < CRC_SPAN)
            crc_run = crc_step(crc_run, b);
        else if (hdr_count < CRC_SPAN + STORED_BYTES)
            stored_acc[BYTE_W*(hdr_count-CRC_SPAN) +: BYTE_W] = b;
        hdr_count++;
        if (hdr_count >= HEADER_BYTES) begin
            if (crc_run == stored_acc)
                queue_verdict(VERDICT_PASS, crc_run, stored_acc);
            else
                queue_verdict(VERDICT_CRC_BAD, crc_run, stored_acc);
            in_session = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit limits_open();
        return lim_min <= lim_max;
    endfunction

    // size inside the current limits, edges favored
    function automatic logic [SIZE_W-1:0] open_size();
        case ($urandom_range(0, 3))
            0: return lim_min;
            1: return lim_max;
            default: return SIZE_W'($urandom_range(lim_min, lim_max));
        endcase
    endfunction

    // any size, biased to the limit boundaries
    function automatic logic [SIZE_W-1:0] pick_size();
        int lo;
        int hi;
        int v;
        lo = lim_min;
        hi = lim_max;
        case ($urandom_range(0, 5))
            0: v = lo - 1;
            1: v = lo;
            2: v = hi;
            3: v = hi + 1;
            4: v = $urandom_range(lo, hi);
            default: v = $urandom_range(0, SIZE_TOP);
        endcase
        if (v < 0)
            v = 0;
        if (v > SIZE_TOP)
            v = SIZE_TOP;
        return SIZE_W'(v);
    endfunction

    // drive one input beat and hold it until accepted
    task automatic push_item(logic cmd, logic [SIZE_W-1:0] size, logic st,
                             logic [BYTE_W-1:0] b);
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_image_size <= size;
        s_staged     <= st;
        s_data_byte  <= b;
        do @(posedge aclk); while (!s_ready);
        if (predict_verdict(cmd, size, st, b))
            items_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_start(logic st, logic [SIZE_W-1:0] size);
        push_item(CMD_START, size, st, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        push_item(CMD_BYTE, SIZE_W'($urandom_range(0, SIZE_TOP)),
                  1'($urandom_range(0, 1)), b);
    endtask

    // full header session, stored word either matching or one bit off
    task automatic send_header(bit make_pass, int extra);
        logic [CRC_W-1:0]  crc;
        logic [CRC_W-1:0]  word;
        logic [BYTE_W-1:0] b;
        crc  = CRC_INIT;
        word = '0;
        send_start(1'b1, open_size());
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i < CRC_SPAN) begin
                b   = BYTE_W'($urandom_range(0, 255));
                crc = crc_step(crc, b);
            end else if (i < CRC_SPAN + STORED_BYTES) begin
                if (i == CRC_SPAN)
                    word = make_pass ? crc : crc ^ (CRC_W'(1) << $urandom_range(0, CRC_W - 1));
                b = word[BYTE_W*(i-CRC_SPAN) +: BYTE_W];
            end else begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            send_byte(b);
        end
        repeat (extra) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // wait for every verdict, then let in-flight beats finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup then access
    task automatic reg_write(logic idx, logic [SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_SIZE)
            lim_min = value;
        else
            lim_max = value;
        @(posedge aclk);
    endtask

    task automatic set_limits(logic [SIZE_W-1:0] lo, logic [SIZE_W-1:0] hi);
        settle();
        reg_write(REG_MIN_SIZE, lo);
        reg_write(REG_MAX_SIZE, hi);
    endtask

    // random mix of sessions, failed starts, aborted headers and stray bytes
    task automatic mixed_traffic(int item_goal, int verdict_goal);
        int items0;
        int verdicts0;
        int budget;
        int pick;
        int nbytes;
        items0    = items_sent;
        verdicts0 = verdicts_due;
        while (items_sent - items0 < item_goal || verdicts_due - verdicts0 < verdict_goal) begin
            budget = item_goal - (items_sent - items0);
            pick   = $urandom_range(0, 99);
            if (pick < 30 && budget > HEADER_BYTES && limits_open()) begin
                send_header(1'($urandom_range(0, 1)), $urandom_range(0, 3));
            end else if (pick < 65 || !limits_open()) begin
                send_start($urandom_range(0, 3) != 0, pick_size());
            end else if (pick < 85) begin
                send_start(1'b1, open_size());
                nbytes = $urandom_range(0, HEADER_BYTES - 1);
                if (nbytes > budget)
                    nbytes = (budget > 0) ? budget : 0;
                repeat (nbytes) send_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // check order and size limits at start, reset limits
    task automatic test_start_checks();
        send_start(1'b0, MIN_SIZE_RESET);
        send_start(1'b0, '0);
        send_start(1'b0, SIZE_W'(SIZE_TOP));
        send_start(1'b1, '0);
        send_start(1'b1, MIN_SIZE_RESET - 1'b1);
        send_start(1'b1, MIN_SIZE_RESET);
        send_start(1'b1, MAX_SIZE_RESET);
        send_start(1'b1, MAX_SIZE_RESET + 1'b1);
        send_start(1'b1, SIZE_W'(SIZE_TOP));
        send_start(1'b1, SIZE_W'(SIZE_TOP - 1));
    endtask

    // bytes while idle are dropped, a start drops a running session
    task automatic test_idle_and_restart();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_start(1'b1, MIN_SIZE_RESET);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_start(1'b1, MAX_SIZE_RESET);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_start(1'b0, MAX_SIZE_RESET);
        send_byte(8'h81);
    endtask

    // one good header, one with a bad stored word plus trailing bytes, then mixed traffic
    task automatic test_header_sessions();
        send_header(1'b1, 0);
        send_header(1'b0, 3);
        mixed_traffic(100, 6);
    endtask

    // limit extremes, including min above max
    task automatic test_limit_settings();
        logic [SIZE_W-1:0] lo;
        set_limits('0, SIZE_W'(SIZE_TOP));
        mixed_traffic(150, 6);
        set_limits('0, '0);
        mixed_traffic(30, 6);
        set_limits(SIZE_W'(SIZE_TOP), SIZE_W'(SIZE_TOP));
        mixed_traffic(30, 6);
        lo = SIZE_W'($urandom_range(1000, SIZE_TOP));
        set_limits(lo, SIZE_W'($urandom_range(0, lo - 1)));
        gaps_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
        mixed_traffic(30, 6);
        lo = SIZE_W'($urandom_range(0, SIZE_TOP));
        set_limits(lo, SIZE_W'($urandom_range(lo, SIZE_TOP)));
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        mixed_traffic(100, 6);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_calm_tail();
        logic [SIZE_W-1:0] lo;
        lo = SIZE_W'($urandom_range(0, 200000));
        set_limits(lo, SIZE_W'($urandom_range(lo, SIZE_TOP)));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        mixed_traffic(150, 8);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_start_checks();
        test_idle_and_restart();
        test_header_sessions();
        test_limit_settings();
        test_calm_tail();
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side backpressure in bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest awaited verdict
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_verdicts.size() == 0) begin
                $error("result beat with nothing awaited: verdict %0d", m_verdict);
                mismatches++;
            end else begin
                want = awaited_verdicts.pop_front();
                if (m_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, m_verdict);
                    mismatches++;
                end
                if (m_computed_crc !== want.computed_crc) begin
                    $error("computed_crc: expected %08h, actual %08h",
                           want.computed_crc, m_computed_crc);
                    mismatches++;
                end
                if (m_stored_crc !== want.stored_crc) begin
                    $error("stored_crc: expected %08h, actual %08h",
                           want.stored_crc, m_stored_crc);
                    mismatches++;
                end
            end
        end
    end

    // stop a hung run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### boot_header_crc_validator.f
src/bhcv_pkg.sv
src/bhcv_cfg_regs.sv
src/bhcv_crc8.sv
src/bhcv_session.sv
src/boot_header_crc_validator.sv
bench/tb.sv
